[rtl/core/assert_macros.svh]
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define RVIG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("rvig check failed");

// Clocked check that also holds through reset.
`define RVIG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("rvig check failed");

`endif

[rtl/core/rvig_pkg.sv]
package rvig_pkg;

   // CSR indexes
   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_STRENGTH = 2'd2;
   localparam logic [1:0] CSR_REACH    = 2'd3;

   localparam int CSR_W   = 13;
   localparam int Q_W     = 10;   // strength and reach, Q2.8
   localparam int CHAN_W  = 8;
   localparam int COORD_W = 12;
   localparam int QUO_W   = 16;   // ratio in Q0.16
   localparam int FAC_W   = 17;   // factor, 65536 is 1.0

   localparam logic [CSR_W-1:0] WIDTH_RST    = 13'd1024;
   localparam logic [CSR_W-1:0] HEIGHT_RST   = 13'd768;
   localparam logic [Q_W-1:0]   STRENGTH_RST = 10'd179;
   localparam logic [Q_W-1:0]   REACH_RST    = 10'd128;

   localparam logic [FAC_W-1:0] FAC_ONE = 17'h10000;

   // Data riding alongside the arithmetic lanes
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              pass;    // zero numerator: factor is 1.0
      logic              black;   // ratio at or above 1.0: factor is 0
   } side_type;

endpackage

[rtl/core/rvig_sqrt_cell.sv]
// One digit of a floor square root: two radicand bits in, one root bit out.
module rvig_sqrt_cell #(
   parameter int RAD_W = 44
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [RAD_W-1:0]     rad_in,
   input  logic [RAD_W/2+1:0]   rem_in,
   input  logic [RAD_W/2-1:0]   root_in,
   output logic [RAD_W-1:0]     rad_out,
   output logic [RAD_W/2+1:0]   rem_out,
   output logic [RAD_W/2-1:0]   root_out
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_ff,  rad_in_n;
   logic [REM_W-1:0]  rem_ff,  rem_in_n;
   logic [ROOT_W-1:0] root_ff, root_in_n;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   // trial subtract of (root*4 + 1)
   always_comb begin
      rem_sh   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial    = {root_in, 2'b01};
      rad_in_n = {rad_in[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in_n  = rem_sh - trial;
         root_in_n = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in_n  = rem_sh;
         root_in_n = {root_in[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in_n;
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
      end
   end

   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
endmodule

[rtl/core/rvig_div_cell.sv]
// One quotient bit of a restoring divide; remainder stays below the divisor.
module rvig_div_cell #(
   parameter int NUM_W = 32
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [NUM_W-1:0]               rem_in,
   input  logic [NUM_W-1:0]               den_in,
   input  logic [rvig_pkg::QUO_W-1:0]     quo_in,
   output logic [NUM_W-1:0]               rem_out,
   output logic [NUM_W-1:0]               den_out,
   output logic [rvig_pkg::QUO_W-1:0]     quo_out
);
   logic [NUM_W-1:0]           rem_ff, rem_in_n;
   logic [NUM_W-1:0]           den_ff;
   logic [rvig_pkg::QUO_W-1:0] quo_ff, quo_in_n;
   logic [NUM_W:0]             r2;
   logic [NUM_W:0]             diff;

   always_comb begin
      r2   = {rem_in, 1'b0};
      diff = r2 - {1'b0, den_in};
      if (r2 >= {1'b0, den_in}) begin
         rem_in_n = diff[NUM_W-1:0];
         quo_in_n = {quo_in[rvig_pkg::QUO_W-2:0], 1'b1};
      end else begin
         rem_in_n = r2[NUM_W-1:0];
         quo_in_n = {quo_in[rvig_pkg::QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_n;
         den_ff <= den_in;
         quo_ff <= quo_in_n;
      end
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;
endmodule

[rtl/core/radial_vignette_pixel_unit.sv]
// Radial vignette, one pixel per transaction.
// Pipeline: the offset squares, the square root chains of one cell per root bit, the
// numerator and denominator registers, the 16-cell divider and the output register.
// Throughput: one pixel per cycle; the whole pipe holds while a result is stalled.
// Reset (synchronous): CSRs return to 1024, 768, 179, 128 and the pipe empties.
module radial_vignette_pixel_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rvig_pkg::COORD_W-1:0]      req_column,
   input  logic [rvig_pkg::COORD_W-1:0]      req_row,
   input  logic [rvig_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [rvig_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [rvig_pkg::CHAN_W-1:0]       req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rvig_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [rvig_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [rvig_pkg::CHAN_W-1:0]       rsp_blue_out,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [rvig_pkg::CSR_W-1:0]        csr_data
);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int DX_W   = (DIM_W > rvig_pkg::COORD_W + 1) ? DIM_W : rvig_pkg::COORD_W + 1;
   localparam int SQ_W   = 2 * DX_W + 1;
   localparam int RAD_W  = SQ_W + 17;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int NUM_W  = ROOT_W + rvig_pkg::Q_W;
   localparam int N_SQ   = ROOT_W;
   localparam int N_DIV  = rvig_pkg::QUO_W;
   localparam int POS_MUL = N_SQ + 1;
   localparam int POS_DIV = N_SQ + 2;
   localparam int LAST   = N_SQ + N_DIV + 1;

   // CSRs
   logic [rvig_pkg::CSR_W-1:0] width_ff, height_ff;
   logic [rvig_pkg::Q_W-1:0]   strength_ff, reach_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rvig_pkg::WIDTH_RST;
         height_ff   <= rvig_pkg::HEIGHT_RST;
         strength_ff <= rvig_pkg::STRENGTH_RST;
         reach_ff    <= rvig_pkg::REACH_RST;
      end else if (csr_write) begin
         case (csr_index)
            rvig_pkg::CSR_WIDTH:    width_ff    <= csr_data;
            rvig_pkg::CSR_HEIGHT:   height_ff   <= csr_data;
            rvig_pkg::CSR_STRENGTH: strength_ff <= csr_data[rvig_pkg::Q_W-1:0];
            rvig_pkg::CSR_REACH:    reach_ff    <= csr_data[rvig_pkg::Q_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the pipe moves unless a finished result is held
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // side band and valid shift line
   logic                 v_ff    [0:LAST];
   rvig_pkg::side_type   side_ff [0:LAST];
   rvig_pkg::side_type   side_in [0:LAST];

   // stage 0: offsets from doubled centre and their squares
   logic [DX_W-1:0]   w_cl, h_cl, col2, row2, dx, dy;
   logic [2*DX_W-1:0] dxsq_ff, dysq_ff, wsq_ff, hsq_ff;

   always_comb begin
      w_cl = (32'(width_ff)  > MAX_DIM) ? DX_W'(MAX_DIM) : DX_W'(width_ff);
      h_cl = (32'(height_ff) > MAX_DIM) ? DX_W'(MAX_DIM) : DX_W'(height_ff);
      col2 = DX_W'({req_column, 1'b0});
      row2 = DX_W'({req_row, 1'b0});
      dx   = (col2 >= w_cl) ? col2 - w_cl : w_cl - col2;
      dy   = (row2 >= h_cl) ? row2 - h_cl : h_cl - row2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dxsq_ff <= dx * dx;
         dysq_ff <= dy * dy;
         wsq_ff  <= w_cl * w_cl;
         hsq_ff  <= h_cl * h_cl;
      end
   end

   // square root chains: pixel distance and half diagonal
   logic [RAD_W-1:0]  rad_p [0:N_SQ];
   logic [REM_W-1:0]  rem_p [0:N_SQ];
   logic [ROOT_W-1:0] root_p[0:N_SQ];
   logic [RAD_W-1:0]  rad_d [0:N_SQ];
   logic [REM_W-1:0]  rem_d [0:N_SQ];
   logic [ROOT_W-1:0] root_d[0:N_SQ];

   assign rad_p[0]  = {1'b0, (SQ_W'(dxsq_ff) + SQ_W'(dysq_ff)), 16'h0000};
   assign rem_p[0]  = '0;
   assign root_p[0] = '0;
   assign rad_d[0]  = {1'b0, (SQ_W'(wsq_ff) + SQ_W'(hsq_ff)), 16'h0000};
   assign rem_d[0]  = '0;
   assign root_d[0] = '0;

   for (genvar k = 0; k < N_SQ; k++) begin : g_sqrt
      rvig_sqrt_cell #(.RAD_W(RAD_W)) u_pix (
         .clock(clock), .en(adv),
         .rad_in(rad_p[k]), .rem_in(rem_p[k]), .root_in(root_p[k]),
         .rad_out(rad_p[k+1]), .rem_out(rem_p[k+1]), .root_out(root_p[k+1])
      );
      rvig_sqrt_cell #(.RAD_W(RAD_W)) u_diag (
         .clock(clock), .en(adv),
         .rad_in(rad_d[k]), .rem_in(rem_d[k]), .root_in(root_d[k]),
         .rad_out(rad_d[k+1]), .rem_out(rem_d[k+1]), .root_out(root_d[k+1])
      );
   end

   // numerator and denominator
   logic [NUM_W-1:0] num_ff, den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= strength_ff * root_p[N_SQ];
         den_ff <= root_d[N_SQ] * reach_ff;
      end
   end

   // divider chain, 16 quotient bits
   logic [NUM_W-1:0]           drem[0:N_DIV];
   logic [NUM_W-1:0]           dden[0:N_DIV];
   logic [rvig_pkg::QUO_W-1:0] dquo[0:N_DIV];

   assign drem[0] = num_ff;
   assign dden[0] = den_ff;
   assign dquo[0] = '0;

   for (genvar j = 0; j < N_DIV; j++) begin : g_div
      rvig_div_cell #(.NUM_W(NUM_W)) u_div (
         .clock(clock), .en(adv),
         .rem_in(drem[j]), .den_in(dden[j]), .quo_in(dquo[j]),
         .rem_out(drem[j+1]), .den_out(dden[j+1]), .quo_out(dquo[j+1])
      );
   end

   // side band moves with the lanes; flags set as the divide starts
   always_comb begin
      side_in[0].red   = req_red_in;
      side_in[0].green = req_green_in;
      side_in[0].blue  = req_blue_in;
      side_in[0].pass  = 1'b0;
      side_in[0].black = 1'b0;
      for (int i = 1; i <= LAST; i++) begin
         side_in[i] = side_ff[i-1];
         if (i == POS_DIV) begin
            side_in[i].pass  = (num_ff == '0);
            side_in[i].black = (num_ff != '0) && (num_ff >= den_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i <= LAST; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= LAST; i++) side_ff[i] <= side_in[i];
      end
   end

   // factor and channel scaling into the output register
   logic [rvig_pkg::FAC_W-1:0] factor;
   logic [rvig_pkg::CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [rvig_pkg::CHAN_W+rvig_pkg::FAC_W-1:0] red_p, green_p, blue_p;

   always_comb begin
      if (side_ff[LAST].pass)       factor = rvig_pkg::FAC_ONE;
      else if (side_ff[LAST].black) factor = '0;
      else factor = rvig_pkg::FAC_ONE - rvig_pkg::FAC_W'(dquo[N_DIV]);
      red_p   = side_ff[LAST].red   * factor;
      green_p = side_ff[LAST].green * factor;
      blue_p  = side_ff[LAST].blue  * factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff   <= red_p[16 +: rvig_pkg::CHAN_W];
         green_ff <= green_p[16 +: rvig_pkg::CHAN_W];
         blue_ff  <= blue_p[16 +: rvig_pkg::CHAN_W];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   // unused lane outputs kept for clarity of the chain ends
   logic unused_tail;
   assign unused_tail = ^{rad_p[N_SQ], rem_p[N_SQ], rad_d[N_SQ], rem_d[N_SQ],
                          drem[N_DIV], dden[N_DIV], POS_MUL[0]};
endmodule

[rtl/core/rvig_checker.sv]
`include "assert_macros.svh"

module rvig_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out
);
   // a held result keeps its valid
   `RVIG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   // a held result keeps its pixel
   `RVIG_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable({rsp_red_out, rsp_green_out, rsp_blue_out}))
   // input backpressure only comes from a held result
   `RVIG_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)
   // reset empties the output
   `RVIG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
endmodule

bind radial_vignette_pixel_unit rvig_checker u_rvig_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_red_out(rsp_red_out),
   .rsp_green_out(rsp_green_out),
   .rsp_blue_out(rsp_blue_out)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int PIPE_LAT    = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 225;

   typedef struct packed {
      logic [rvig_pkg::COORD_W-1:0] column;
      logic [rvig_pkg::COORD_W-1:0] row;
      logic [rvig_pkg::CHAN_W-1:0]  red;
      logic [rvig_pkg::CHAN_W-1:0]  green;
      logic [rvig_pkg::CHAN_W-1:0]  blue;
   } pixel_type;

   typedef struct packed {
      logic [rvig_pkg::CHAN_W-1:0] red;
      logic [rvig_pkg::CHAN_W-1:0] green;
      logic [rvig_pkg::CHAN_W-1:0] blue;
   } shade_type;

   typedef enum {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   index;
      logic [rvig_pkg::CSR_W-1:0] data;
      pixel_type    pix;
      bit           typed;
      shade_type    shade;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [rvig_pkg::COORD_W-1:0] req_column = '0;
   logic [rvig_pkg::COORD_W-1:0] req_row = '0;
   logic [rvig_pkg::CHAN_W-1:0]  req_red_in = '0;
   logic [rvig_pkg::CHAN_W-1:0]  req_green_in = '0;
   logic [rvig_pkg::CHAN_W-1:0]  req_blue_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [rvig_pkg::CHAN_W-1:0]  rsp_red_out;
   logic [rvig_pkg::CHAN_W-1:0]  rsp_green_out;
   logic [rvig_pkg::CHAN_W-1:0]  rsp_blue_out;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [rvig_pkg::CSR_W-1:0] csr_data = '0;

   // shadow of the block's registers
   logic [rvig_pkg::CSR_W-1:0] img_w = rvig_pkg::WIDTH_RST;
   logic [rvig_pkg::CSR_W-1:0] img_h = rvig_pkg::HEIGHT_RST;
   logic [rvig_pkg::Q_W-1:0]   gain = rvig_pkg::STRENGTH_RST;
   logic [rvig_pkg::Q_W-1:0]   radius = rvig_pkg::REACH_RST;

   shade_type    shade_q[$];
   stim_row_type plan[$];
   int        err_count = 0;
   int        cycles = 0;
   bit        quiet = 1'b0;
   bit        hold_request = 1'b0;

   radial_vignette_pixel_unit i_dut (.*);

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // darkened pixel for the current register settings
   function automatic shade_type vignette(pixel_type p);
      longint unsigned w, h, c2, r2, dx, dy, pix_dist, diag, num, den, q, factor;
      shade_type s;
      w = (img_w > 4096) ? 4096 : img_w;
      h = (img_h > 4096) ? 4096 : img_h;
      c2 = 2 * longint'(p.column);
      r2 = 2 * longint'(p.row);
      dx = (c2 >= w) ? c2 - w : w - c2;
      dy = (r2 >= h) ? r2 - h : h - r2;
      pix_dist = int_sqrt((dx * dx + dy * dy) << 16);
      diag = int_sqrt((w * w + h * h) << 16);
      num = longint'(gain) * pix_dist;
      den = diag * longint'(radius);
      if (num == 0) factor = 65536;
      else if (den == 0) factor = 0;
      else begin
         q = (num << 16) / den;
         factor = (q < 65536) ? 65536 - q : 0;
      end
      s.red   = 8'((longint'(p.red) * factor) >> 16);
      s.green = 8'((longint'(p.green) * factor) >> 16);
      s.blue  = 8'((longint'(p.blue) * factor) >> 16);
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // check each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shade_q.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            if (rsp_red_out !== shade_q[0].red)
               report_mismatch("red_out", rsp_red_out, shade_q[0].red);
            if (rsp_green_out !== shade_q[0].green)
               report_mismatch("green_out", rsp_green_out, shade_q[0].green);
            if (rsp_blue_out !== shade_q[0].blue)
               report_mismatch("blue_out", rsp_blue_out, shade_q[0].blue);
            void'(shade_q.pop_front());
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (300) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // one pixel transaction; called and returns at a falling edge
   task automatic send_pixel(pixel_type p, bit typed, shade_type want);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid = 1'b1;
      {req_column, req_row, req_red_in, req_green_in, req_blue_in} = p;
      do @(posedge clock); while (req_stall);
      shade_q.push_back(typed ? want : vignette(p));
      @(negedge clock);
   endtask

   // register write, only with the pipe empty
   task automatic write_csr(logic [1:0] idx, logic [rvig_pkg::CSR_W-1:0] value);
      req_valid = 1'b0;
      while (shade_q.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 8) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         rvig_pkg::CSR_WIDTH:    img_w = value;
         rvig_pkg::CSR_HEIGHT:   img_h = value;
         rvig_pkg::CSR_STRENGTH: gain = value[rvig_pkg::Q_W-1:0];
         rvig_pkg::CSR_REACH:    radius = value[rvig_pkg::Q_W-1:0];
         default: ;
      endcase
   endtask

   function automatic void add_pixel(int c, int r, int red, int grn, int blu,
                                     bit typed = 0, int er = 0, int eg = 0, int eb = 0);
      stim_row_type s;
      s.kind = ROW_PIXEL;
      s.index = rvig_pkg::CSR_WIDTH;
      s.data = '0;
      s.pix = '{12'(c), 12'(r), 8'(red), 8'(grn), 8'(blu)};
      s.typed = typed;
      s.shade = '{8'(er), 8'(eg), 8'(eb)};
      plan.push_back(s);
   endfunction

   function automatic void add_csr(logic [1:0] idx, int value);
      stim_row_type s;
      s.kind = ROW_CSR;
      s.index = idx;
      s.data = rvig_pkg::CSR_W'(value);
      s.pix = '0;
      s.typed = 0;
      s.shade = '0;
      plan.push_back(s);
   endfunction

   function automatic logic [rvig_pkg::CSR_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 13'd1;
         1: return 13'd4096;
         2: return 13'd8191;
         3: return ($urandom_range(0, 3) == 0) ? 13'd0 : 13'd16;
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [rvig_pkg::CSR_W-1:0] pick_q(bit allow_zero);
      case ($urandom_range(0, 7))
         0: return allow_zero ? 13'd0 : 13'd1;
         1: return 13'd1023;
         2: return 13'd1;
         3: return 13'd256;
         default: return 13'($urandom_range(0, 8191));   // upper bits dropped
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int w, h;
      w = (img_w == 0) ? 1 : ((img_w > 4096) ? 4096 : int'(img_w));
      h = (img_h == 0) ? 1 : ((img_h > 4096) ? 4096 : int'(img_h));
      if ($urandom_range(0, 3) != 0) begin
         p.column = 12'($urandom_range(0, w - 1));
         p.row = 12'($urandom_range(0, h - 1));
      end else begin
         p.column = 12'($urandom);
         p.row = 12'($urandom);
      end
      p.red = 8'($urandom);
      p.green = 8'($urandom);
      p.blue = 8'($urandom);
      return p;
   endfunction

   initial begin
      // directed table: reset values, extremes, special cases
      add_pixel(512, 384, 255, 128, 1, 1, 255, 128, 1);   // centre: factor 1.0
      add_pixel(0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_pixel(0, 0, 255, 255, 255);
      add_pixel(4095, 4095, 255, 255, 255);
      add_pixel(1023, 767, 200, 100, 50);
      add_csr(rvig_pkg::CSR_REACH, 0);                    // zero divisor
      add_pixel(0, 0, 255, 255, 255, 1, 0, 0, 0);
      add_pixel(512, 384, 255, 255, 255, 1, 255, 255, 255);
      add_csr(rvig_pkg::CSR_STRENGTH, 0);                 // zero intensity
      add_pixel(4095, 4095, 255, 255, 255, 1, 255, 255, 255);
      add_csr(rvig_pkg::CSR_WIDTH, 8191);                 // oversized image
      add_csr(rvig_pkg::CSR_HEIGHT, 8191);
      add_csr(rvig_pkg::CSR_STRENGTH, 1023);
      add_csr(rvig_pkg::CSR_REACH, 1);
      add_pixel(2048, 2048, 255, 255, 255, 1, 255, 255, 255);
      add_pixel(0, 0, 170, 85, 255);
      add_pixel(2049, 2048, 255, 255, 255);
      add_csr(rvig_pkg::CSR_WIDTH, 0);                    // zero-sized image
      add_csr(rvig_pkg::CSR_HEIGHT, 0);
      add_pixel(0, 0, 255, 255, 255, 1, 255, 255, 255);
      add_pixel(1, 0, 255, 255, 255, 1, 0, 0, 0);
      add_csr(rvig_pkg::CSR_WIDTH, 1);
      add_csr(rvig_pkg::CSR_HEIGHT, 1);
      add_csr(rvig_pkg::CSR_STRENGTH, 13'h1D00);          // masks to 256
      add_csr(rvig_pkg::CSR_REACH, 1023);
      add_pixel(0, 0, 255, 255, 255);
      add_pixel(4095, 0, 255, 255, 255);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_csr(plan[i].index, plan[i].data);
         else send_pixel(plan[i].pix, plan[i].typed, plan[i].shade);
      end

      // random phases with fresh register settings
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(rvig_pkg::CSR_WIDTH, pick_dim());
         write_csr(rvig_pkg::CSR_HEIGHT, pick_dim());
         write_csr(rvig_pkg::CSR_STRENGTH, pick_q(1));
         write_csr(rvig_pkg::CSR_REACH, pick_q($urandom_range(0, 5) == 0));
         if (ph == 1) hold_request = 1'b1;
         if (ph == PHASES - 1) quiet = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(random_pixel(), 0, '0);
      end
      req_valid = 1'b0;

      while (shade_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
